// ----- src/ntc_pkg.sv -----
// Shared constants, codes and types of the NTC sample-to-temperature pipeline.
// Depends on nothing; every other file refers to it by scoped names.
package ntc_pkg;

	// Converter resolution; full scale is the all-ones code.
	localparam int ADC_BITS = 12;
	localparam logic [ADC_BITS-1:0] FULL_SCALE = '1;

	// Log operand, mantissa and result widths.
	localparam int OPND_W = 24;
	localparam int FRAC_BITS = 24;
	localparam int TOP_W = 5;
	localparam int LOG_W = TOP_W + FRAC_BITS;
	localparam int MANT_W = 31;

	// Fixed-point constants, Q24; the Kelvin offset is in half-tenths of a degree.
	localparam logic [23:0] LN2_Q24 = 24'd11629080;
	localparam logic [31:0] INV_T0_Q24 = 32'd56271;
	localparam logic [12:0] KELVIN_OFFSET_HALF_TENTHS = 13'd5463;
	localparam logic [31:0] NUM_BASE = 32'd335544320;

	// Register indexes of the write port.
	typedef enum logic [2:0] {
		REG_BETA    = 3'd0,
		REG_NOMINAL = 3'd1,
		REG_DIVIDER = 3'd2,
		REG_OPEN    = 3'd3,
		REG_SHORT   = 3'd4
	} reg_idx_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_FAIL  = 2'd1,
		ST_OPEN  = 2'd2,
		ST_SHORT = 2'd3
	} status_t;

	// Control that travels with each word down the pipeline.
	typedef struct packed {
		logic    valid;
		status_t status;
	} tag_t;

endpackage

// ----- src/ntc_log2.sv -----
// One log2 lane: normalize, then 24 squaring stages, result unsigned Q24.
// Depends on ntc_pkg.
module ntc_log2 (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        adv,
	input  logic [ntc_pkg::OPND_W-1:0]  opnd,
	input  ntc_pkg::tag_t               tag_in,
	output ntc_pkg::tag_t               tag_out,
	output logic [ntc_pkg::LOG_W-1:0]   log_q24
);

	localparam int NSTG = ntc_pkg::FRAC_BITS;

	logic [ntc_pkg::MANT_W-1:0]    y_s [0:NSTG];
	logic [ntc_pkg::FRAC_BITS-1:0] f_s [0:NSTG];
	logic [ntc_pkg::TOP_W-1:0]     t_s [0:NSTG];
	ntc_pkg::tag_t                 g_s [0:NSTG];

	logic [ntc_pkg::OPND_W-1:0] n1;
	logic [ntc_pkg::TOP_W-1:0]  top;

	// Zero is taken as one; find the top bit.
	always_comb begin
		n1 = (opnd == '0) ? ntc_pkg::OPND_W'(1) : opnd;
		top = '0;
		for (int i = 0; i < ntc_pkg::OPND_W; i++) begin
			if (n1[i]) top = ntc_pkg::TOP_W'(i);
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			y_s[0] <= ntc_pkg::MANT_W'(n1) << (5'd30 - top);
			f_s[0] <= '0;
			t_s[0] <= top;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			g_s[0] <= '0;
		end else if (adv) begin
			g_s[0] <= tag_in;
		end
	end

	for (genvar k = 1; k <= NSTG; k++) begin : g_sq
		logic [2*ntc_pkg::MANT_W-1:0] sq;
		logic [ntc_pkg::MANT_W:0]     sh;

		always_comb begin
			sq = (2*ntc_pkg::MANT_W)'(y_s[k-1]) * (2*ntc_pkg::MANT_W)'(y_s[k-1]);
			sh = sq[2*ntc_pkg::MANT_W-1:ntc_pkg::MANT_W-1];
		end

		// Square; on overflow past two, halve and set this fraction bit.
		always_ff @(posedge clk) begin
			if (adv) begin
				y_s[k] <= sh[ntc_pkg::MANT_W] ? sh[ntc_pkg::MANT_W:1]
				                              : sh[ntc_pkg::MANT_W-1:0];
				f_s[k] <= f_s[k-1] | (sh[ntc_pkg::MANT_W]
				          ? (ntc_pkg::FRAC_BITS'(1) << (NSTG - k)) : '0);
				t_s[k] <= t_s[k-1];
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				g_s[k] <= '0;
			end else if (adv) begin
				g_s[k] <= g_s[k-1];
			end
		end
	end

	assign log_q24 = {t_s[NSTG], f_s[NSTG]};
	assign tag_out = g_s[NSTG];

endmodule

// ----- src/ntc_recip.sv -----
// Reciprocal temperature: log sum, scale by ln 2, divide by Beta, add 1/T0.
// Depends on ntc_pkg.
module ntc_recip (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       adv,
	input  ntc_pkg::tag_t              tag_in,
	input  logic [ntc_pkg::LOG_W-1:0]  l_r1,
	input  logic [ntc_pkg::LOG_W-1:0]  l_code,
	input  logic [ntc_pkg::LOG_W-1:0]  l_r25,
	input  logic [ntc_pkg::LOG_W-1:0]  l_fs,
	input  logic [15:0]                beta,
	output ntc_pkg::tag_t              tag_out,
	output logic [31:0]                inv
);

	localparam int QW = 30;

	logic [30:0]   l_s1;
	ntc_pkg::tag_t g_s1;
	logic [QW-1:0] mag;
	logic [53:0]   prod;

	logic [15:0]   rem_s [0:QW];
	logic [QW-1:0] dq_s  [0:QW];
	logic          neg_s [0:QW];
	ntc_pkg::tag_t g_s   [0:QW];

	logic [31:0]   inv_s3;
	ntc_pkg::tag_t g_s3;

	always_comb begin
		mag = l_s1[30] ? QW'(-l_s1) : l_s1[QW-1:0];
		prod = 54'(mag) * 54'(ntc_pkg::LN2_Q24);
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			l_s1 <= 31'(l_r1) + 31'(l_code) - 31'(l_r25) - 31'(l_fs);
			rem_s[0] <= '0;
			dq_s[0] <= prod[53:24];
			neg_s[0] <= l_s1[30];
			inv_s3 <= ntc_pkg::INV_T0_Q24 + (neg_s[QW] ? -32'(dq_s[QW]) : 32'(dq_s[QW]));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			g_s1 <= '0;
			g_s[0] <= '0;
			g_s3 <= '0;
		end else if (adv) begin
			g_s1 <= tag_in;
			g_s[0] <= g_s1;
			g_s3 <= g_s[QW];
		end
	end

	// Restoring division, one quotient bit per stage.
	for (genvar k = 1; k <= QW; k++) begin : g_div
		logic [16:0] t;
		logic [16:0] d;
		logic        ge;

		always_comb begin
			t = {rem_s[k-1], dq_s[k-1][QW-1]};
			ge = t >= {1'b0, beta};
			d = t - {1'b0, beta};
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				rem_s[k] <= ge ? d[15:0] : t[15:0];
				dq_s[k] <= {dq_s[k-1][QW-2:0], ge};
				neg_s[k] <= neg_s[k-1];
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				g_s[k] <= '0;
			end else if (adv) begin
				g_s[k] <= g_s[k-1];
			end
		end
	end

	assign inv = inv_s3;
	assign tag_out = g_s3;

endmodule

// ----- src/ntc_scale.sv -----
// Tenths of a degree from the reciprocal: offset, 16-bit divide, clamp.
// Depends on ntc_pkg; its last stage is the output register.
module ntc_scale (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          adv,
	input  ntc_pkg::tag_t tag_in,
	input  logic [31:0]   inv,
	output ntc_pkg::tag_t tag_out,
	output logic [15:0]   temp
);

	localparam int QB = 16;

	typedef enum logic [1:0] {
		RES_DIV  = 2'd0,
		RES_MAX  = 2'd1,
		RES_ZERO = 2'd2
	} res_t;

	logic [43:0]   p_s1;
	logic [30:0]   inv_s1;
	logic          pos_s1;
	ntc_pkg::tag_t g_s1;

	logic          negnum;
	logic [31:0]   num;
	logic [31:0]   a_val;
	logic [19:0]   b_val;
	logic          big;
	res_t          mode;

	logic [31:0]   rem_s  [0:QB];
	logic [19:0]   b_s    [0:QB];
	logic [QB-1:0] q_s    [0:QB];
	res_t          mode_s [0:QB];
	ntc_pkg::tag_t g_s    [0:QB];

	logic [15:0]   temp_q;
	ntc_pkg::tag_t g_q;

	always_comb begin
		negnum = p_s1 > 44'(ntc_pkg::NUM_BASE);
		num = ntc_pkg::NUM_BASE - p_s1[31:0];
		a_val = (num << 1) + {inv_s1, 1'b0};
		b_val = {inv_s1[17:0], 2'b00};
		big = {16'b0, a_val} >= {12'b0, b_val, 16'b0};
		if (!pos_s1) mode = RES_MAX;
		else if (negnum) mode = RES_ZERO;
		else if (big) mode = RES_MAX;
		else mode = RES_DIV;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			pos_s1 <= !inv[31] && (inv != '0);
			inv_s1 <= inv[30:0];
			p_s1 <= 44'(inv[30:0]) * 44'(ntc_pkg::KELVIN_OFFSET_HALF_TENTHS);
			rem_s[0] <= a_val;
			b_s[0] <= b_val;
			q_s[0] <= '0;
			mode_s[0] <= mode;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			g_s1 <= '0;
			g_s[0] <= '0;
		end else if (adv) begin
			g_s1 <= tag_in;
			g_s[0] <= g_s1;
		end
	end

	for (genvar j = 1; j <= QB; j++) begin : g_div
		logic [35:0] shb;
		logic        ge;

		always_comb begin
			shb = {b_s[j-1], 16'b0} >> j;
			ge = 36'(rem_s[j-1]) >= shb;
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				rem_s[j] <= ge ? 32'(36'(rem_s[j-1]) - shb) : rem_s[j-1];
				b_s[j] <= b_s[j-1];
				q_s[j] <= q_s[j-1] | (ge ? (QB'(1) << (QB - j)) : '0);
				mode_s[j] <= mode_s[j-1];
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				g_s[j] <= '0;
			end else if (adv) begin
				g_s[j] <= g_s[j-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			if (g_s[QB].status != ntc_pkg::ST_OK) temp_q <= '0;
			else begin
				case (mode_s[QB])
					RES_MAX:  temp_q <= '1;
					RES_ZERO: temp_q <= '0;
					default:  temp_q <= q_s[QB];
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			g_q <= '0;
		end else if (adv) begin
			g_q <= g_s[QB];
		end
	end

	assign temp = temp_q;
	assign tag_out = g_q;

endmodule

// ----- src/ntc_adc_to_temperature.sv -----
// Top level of the NTC sample-to-temperature converter.
// Depends on ntc_pkg, ntc_log2, ntc_recip and ntc_scale.

// One converter sample in, one result out, a new word accepted every cycle
// unless the pipeline is stalled. Each word runs through a 78-stage pipeline
// (input register, four parallel log2 lanes of 25 stages, 33 stages for the
// Beta division, 19 for the final division and clamp). The whole pipeline
// advances as one: a result-side stall with a result word presented holds
// every stage and raises the sample-side stall in the same cycle. Status is
// settled at the input (read failure first, then open circuit, then short); a
// word with nonzero status reports zero temperature.
// Write registers only while the pipeline holds no word.
module ntc_adc_to_temperature (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        sample_valid,
	output logic        sample_stall,
	input  logic [11:0] adc_code,
	input  logic        conversion_failed,
	output logic        result_valid,
	input  logic        result_stall,
	output logic [15:0] temp_tenths,
	output logic [1:0]  status,
	input  logic        wr_en,
	input  logic [2:0]  wr_index,
	input  logic [23:0] wr_data
);

	logic [15:0] beta_q;
	logic [23:0] nominal_q;
	logic [23:0] divider_q;
	logic [11:0] open_q;
	logic [11:0] short_q;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			beta_q <= 16'd3950;
			nominal_q <= 24'd10000;
			divider_q <= 24'd10000;
			open_q <= 12'd4090;
			short_q <= 12'd5;
		end else if (wr_en) begin
			unique case (wr_index)
				ntc_pkg::REG_BETA:    beta_q <= wr_data[15:0];
				ntc_pkg::REG_NOMINAL: nominal_q <= wr_data;
				ntc_pkg::REG_DIVIDER: divider_q <= wr_data;
				ntc_pkg::REG_OPEN:    open_q <= wr_data[11:0];
				ntc_pkg::REG_SHORT:   short_q <= wr_data[11:0];
				default: ;
			endcase
		end
	end

	logic adv;
	ntc_pkg::tag_t tag_out;

	// Advance unless a finished word is held by the receiver.
	assign adv = !(tag_out.valid && result_stall);
	assign sample_stall = !adv;

	// Classify the sample; only the low ADC_BITS bits count.
	logic [ntc_pkg::ADC_BITS-1:0] code;
	ntc_pkg::status_t st;

	always_comb begin
		code = adc_code[ntc_pkg::ADC_BITS-1:0];
		if (conversion_failed) st = ntc_pkg::ST_FAIL;
		else if (12'(code) >= open_q || code == ntc_pkg::FULL_SCALE) st = ntc_pkg::ST_OPEN;
		else if (12'(code) <= short_q || code == '0) st = ntc_pkg::ST_SHORT;
		else st = ntc_pkg::ST_OK;
	end

	logic [ntc_pkg::ADC_BITS-1:0] code_s1;
	ntc_pkg::tag_t tag_s1;

	always_ff @(posedge clk) begin
		if (adv) code_s1 <= code;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s1 <= '0;
		end else if (adv) begin
			tag_s1 <= '{valid: sample_valid, status: st};
		end
	end

	// Four log lanes; zero resistors are read as one inside each lane.
	logic [ntc_pkg::LOG_W-1:0] l_r1, l_code, l_r25, l_fs;
	ntc_pkg::tag_t tag_log;
	logic [ntc_pkg::OPND_W-1:0] rest;

	assign rest = ntc_pkg::OPND_W'(ntc_pkg::FULL_SCALE - code_s1);

	ntc_log2 u_log_r1 (
		.clk(clk), .arst_n(arst_n), .adv(adv), .opnd(divider_q),
		.tag_in(tag_s1), .tag_out(tag_log), .log_q24(l_r1)
	);
	ntc_log2 u_log_code (
		.clk(clk), .arst_n(arst_n), .adv(adv), .opnd(ntc_pkg::OPND_W'(code_s1)),
		.tag_in(tag_s1), .tag_out(), .log_q24(l_code)
	);
	ntc_log2 u_log_r25 (
		.clk(clk), .arst_n(arst_n), .adv(adv), .opnd(nominal_q),
		.tag_in(tag_s1), .tag_out(), .log_q24(l_r25)
	);
	ntc_log2 u_log_fs (
		.clk(clk), .arst_n(arst_n), .adv(adv), .opnd(rest),
		.tag_in(tag_s1), .tag_out(), .log_q24(l_fs)
	);

	logic [15:0] beta_eff;
	logic [31:0] inv;
	ntc_pkg::tag_t tag_inv;

	// Zero Beta is read as one.
	assign beta_eff = (beta_q == '0) ? 16'd1 : beta_q;

	ntc_recip u_recip (
		.clk(clk), .arst_n(arst_n), .adv(adv), .tag_in(tag_log),
		.l_r1(l_r1), .l_code(l_code), .l_r25(l_r25), .l_fs(l_fs),
		.beta(beta_eff), .tag_out(tag_inv), .inv(inv)
	);

	ntc_scale u_scale (
		.clk(clk), .arst_n(arst_n), .adv(adv), .tag_in(tag_inv),
		.inv(inv), .tag_out(tag_out), .temp(temp_tenths)
	);

	assign result_valid = tag_out.valid;
	assign status = tag_out.status;

`ifndef SYNTHESIS
	// A word with a fault status carries zero temperature.
	a_fault_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && (status != ntc_pkg::ST_OK) |-> temp_tenths == '0)
		else $error("fault word with nonzero temperature");

	// A held result word stays presented.
	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid)
		else $error("result word dropped while stalled");

	// The sample side stalls exactly when the result side holds a word.
	a_stall_link: assert property (@(posedge clk) disable iff (!arst_n)
		sample_stall == (result_valid && result_stall))
		else $error("sample stall out of step with result stall");
`endif

endmodule
